FILE: rtl/priority_process_scheduler_tick_defines.svh
// Assertion macros for the priority process scheduler.
// Used by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef PRIORITY_PROCESS_SCHEDULER_TICK_DEFINES_SVH
`define PRIORITY_PROCESS_SCHEDULER_TICK_DEFINES_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pps: check failed");
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pps: check failed");
`else
`define PPS_ASSERT(lbl, prop)
`define PPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/pps_pkg.sv
// Shared types and constants of the priority process scheduler.
// No dependencies.
package pps_pkg;

    localparam int MAX_PROCESSES_DEF = 16;

    typedef enum logic [2:0] {
        PH_NEW        = 3'd0,
        PH_READY      = 3'd1,
        PH_RUNNING    = 3'd2,
        PH_WAITING    = 3'd3,
        PH_TERMINATED = 3'd4
    } t_phase;

    typedef enum logic {
        OP_ADMIT = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic {
        STS_OK   = 1'b0,
        STS_FULL = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        RA_NONE,
        RA_TERM,
        RA_WAIT
    } t_run_act;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADMIT,
        S_RUN_RD,
        S_RUN_EV,
        S_WF_RD,
        S_WS_RD,
        S_WS_EV,
        S_WAPPEND,
        S_RUN_EMIT,
        S_SCAN,
        S_DISP,
        S_TICK_END,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [7:0]  pid;
        logic [15:0] burst_time;
        logic [15:0] io_every;
        logic [15:0] io_length;
    } t_req;

    typedef struct packed {
        logic [31:0] now;
        logic [7:0]  proc_id;
        logic [2:0]  from_state;
        logic [2:0]  new_state;
        t_status     status;
    } t_evt;

    typedef struct packed {
        logic [31:0] now;
        logic [7:0]  proc_id;
        logic [2:0]  from_state;
        logic [2:0]  new_state;
        t_status     status;
        logic        all_done;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0]  pid;
        t_phase      phase;
        logic [15:0] burst_left;
        logic [15:0] io_every;
        logic [15:0] io_length;
        logic [15:0] until_io;
        logic [15:0] io_left;
    } t_slot;

    typedef struct packed {
        logic emit;
        logic fin;
        t_evt evt;
    } t_emit_req;

    typedef struct packed {
        logic emit_ok;
        logic fin_ok;
    } t_emit_ack;

endpackage

FILE: rtl/pps_if.sv
// Request and result channel interfaces of the priority process scheduler.
// Depends on pps_pkg.
interface pps_req_if;
    logic            valid;
    logic            ready;
    pps_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pps_res_if;
    logic            valid;
    logic            ready;
    pps_pkg::t_res   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pps_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on pps_pkg for default sizes.
module pps_ram #(
    parameter int WIDTH = $bits(pps_pkg::t_slot),
    parameter int DEPTH = pps_pkg::MAX_PROCESSES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/pps_emit.sv
// Result stage: holds one request back so the final one can be marked last.
// Depends on pps_pkg and pps_if.
module pps_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pps_pkg::t_emit_req    i_emit,
    input  logic                  i_all_done,
    output pps_pkg::t_emit_ack    o_ack,
    pps_res_if.source             o_res
);
    logic            r_pend_v, n_pend_v;
    pps_pkg::t_evt   r_pend, n_pend;
    logic            r_out_v, n_out_v;
    pps_pkg::t_res   r_out, n_out;
    logic            out_free;

    assign out_free      = !r_out_v || o_res.ready;
    assign o_ack.emit_ok = !r_pend_v || out_free;
    assign o_ack.fin_ok  = !r_pend_v || out_free;
    assign o_res.valid   = r_out_v;
    assign o_res.data    = r_out;

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v;
        n_out    = r_out;
        if (out_free) begin
            n_out_v = 1'b0;
        end
        if (i_emit.emit && o_ack.emit_ok) begin
            // push the held request out, hold the new one
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = {r_pend, i_all_done, 1'b0};
            end
            n_pend_v = 1'b1;
            n_pend   = i_emit.evt;
        end else if (i_emit.fin && o_ack.fin_ok && r_pend_v) begin
            n_out_v  = 1'b1;
            n_out    = {r_pend, i_all_done, 1'b1};
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end
endmodule

FILE: rtl/pps_ctrl.sv
// Sequencer of the scheduler: owns the slot table and wait list memories.
// Depends on pps_pkg, pps_if, pps_ram and the assertion macro header.
`include "priority_process_scheduler_tick_defines.svh"
module pps_ctrl #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF,
    localparam int SW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int CW = $clog2(MAX_PROCESSES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pps_req_if.sink               i_req,
    output pps_pkg::t_emit_req    o_emit,
    input  pps_pkg::t_emit_ack    i_ack,
    output logic                  o_all_done
);
    localparam int SLOT_W = $bits(pps_pkg::t_slot);

    pps_pkg::t_state   r_state, n_state;
    pps_pkg::t_req     r_req, n_req;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_live, n_live;
    logic [CW-1:0]     r_wcnt, n_wcnt;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_kept, n_kept;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_sv, n_sv;
    logic [SW-1:0]     r_sidx, n_sidx;
    logic [SW-1:0]     r_run, n_run;
    logic              r_busy, n_busy;
    logic [31:0]       r_tick, n_tick;
    pps_pkg::t_run_act r_act, n_act;
    logic [7:0]        r_run_pid, n_run_pid;
    logic [SW-1:0]     r_ws, n_ws;
    logic [SW-1:0]     r_best, n_best;
    logic              r_best_ok, n_best_ok;
    pps_pkg::t_slot    r_best_ent, n_best_ent;

    logic              slot_we, slot_re;
    logic [SW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_rdata;
    pps_pkg::t_slot    slot_wdata;
    pps_pkg::t_slot    ent;
    pps_pkg::t_slot    work;
    logic              fifo_we, fifo_re;
    logic [SW-1:0]     fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
    logic              full;
    logic              admit_wr;

    pps_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCESSES)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    pps_ram #(.WIDTH(SW), .DEPTH(MAX_PROCESSES)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_re    (fifo_re),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    assign ent        = pps_pkg::t_slot'(slot_rdata);
    assign full       = (r_fill == CW'(MAX_PROCESSES));
    assign o_all_done = (r_fill != '0) && (r_live == '0);
    assign admit_wr   = (r_state == pps_pkg::S_ADMIT) && i_ack.emit_ok && !full;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_fill     = r_fill;
        n_live     = r_live;
        n_wcnt     = r_wcnt;
        n_k        = r_k;
        n_kept     = r_kept;
        n_scan     = r_scan;
        n_sv       = r_sv;
        n_sidx     = r_sidx;
        n_run      = r_run;
        n_busy     = r_busy;
        n_tick     = r_tick;
        n_act      = r_act;
        n_run_pid  = r_run_pid;
        n_ws       = r_ws;
        n_best     = r_best;
        n_best_ok  = r_best_ok;
        n_best_ent = r_best_ent;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = '0;
        slot_raddr = '0;
        slot_wdata = ent;
        work       = ent;
        fifo_we    = 1'b0;
        fifo_re    = 1'b0;
        fifo_waddr = '0;
        fifo_raddr = '0;
        fifo_wdata = '0;
        i_req.ready = 1'b0;
        o_emit.emit = 1'b0;
        o_emit.fin  = 1'b0;
        o_emit.evt.now        = r_tick;
        o_emit.evt.proc_id    = ent.pid;
        o_emit.evt.from_state = pps_pkg::PH_NEW;
        o_emit.evt.new_state  = pps_pkg::PH_NEW;
        o_emit.evt.status     = pps_pkg::STS_OK;

        case (r_state)
            pps_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_state = (i_req.data.op == pps_pkg::OP_ADMIT) ? pps_pkg::S_ADMIT
                                                                   : pps_pkg::S_RUN_RD;
                end
            end
            pps_pkg::S_ADMIT: begin
                o_emit.emit        = 1'b1;
                o_emit.evt.proc_id = r_req.pid;
                if (full) begin
                    o_emit.evt.status = pps_pkg::STS_FULL;
                end else begin
                    o_emit.evt.new_state = pps_pkg::PH_READY;
                end
                if (admit_wr) begin
                    slot_we               = 1'b1;
                    slot_waddr            = r_fill[SW-1:0];
                    slot_wdata.pid        = r_req.pid;
                    slot_wdata.phase      = pps_pkg::PH_READY;
                    slot_wdata.burst_left = r_req.burst_time;
                    slot_wdata.io_every   = r_req.io_every;
                    slot_wdata.io_length  = r_req.io_length;
                    slot_wdata.until_io   = r_req.io_every;
                    slot_wdata.io_left    = '0;
                    n_fill = r_fill + CW'(1);
                    n_live = r_live + CW'(1);
                end
                if (i_ack.emit_ok) begin
                    n_state = pps_pkg::S_FINISH;
                end
            end
            pps_pkg::S_RUN_RD: begin
                n_act  = pps_pkg::RA_NONE;
                n_k    = '0;
                n_kept = '0;
                if (r_busy) begin
                    slot_re    = 1'b1;
                    slot_raddr = r_run;
                    n_state    = pps_pkg::S_RUN_EV;
                end else begin
                    n_state = pps_pkg::S_WF_RD;
                end
            end
            pps_pkg::S_RUN_EV: begin
                // charge one tick to the running process
                if (ent.burst_left != '0) begin
                    work.burst_left = ent.burst_left - 16'd1;
                end
                if (ent.io_every != '0 && ent.until_io != '0) begin
                    work.until_io = ent.until_io - 16'd1;
                end
                if (work.burst_left == '0) begin
                    work.phase = pps_pkg::PH_TERMINATED;
                    n_act      = pps_pkg::RA_TERM;
                    n_live     = r_live - CW'(1);
                    n_busy     = 1'b0;
                end else if (ent.io_every != '0 && work.until_io == '0) begin
                    work.phase    = pps_pkg::PH_WAITING;
                    work.io_left  = ent.io_length;
                    work.until_io = ent.io_every;
                    n_act         = pps_pkg::RA_WAIT;
                    n_busy        = 1'b0;
                end
                slot_we    = 1'b1;
                slot_waddr = r_run;
                slot_wdata = work;
                n_run_pid  = ent.pid;
                n_state    = pps_pkg::S_WF_RD;
            end
            pps_pkg::S_WF_RD: begin
                if (r_k == r_wcnt) begin
                    n_state = pps_pkg::S_WAPPEND;
                end else begin
                    fifo_re    = 1'b1;
                    fifo_raddr = r_k[SW-1:0];
                    n_state    = pps_pkg::S_WS_RD;
                end
            end
            pps_pkg::S_WS_RD: begin
                n_ws       = fifo_rdata;
                slot_re    = 1'b1;
                slot_raddr = fifo_rdata;
                n_state    = pps_pkg::S_WS_EV;
            end
            pps_pkg::S_WS_EV: begin
                if (ent.io_left != '0) begin
                    work.io_left = ent.io_left - 16'd1;
                end
                if (work.io_left == '0) begin
                    // release to ready
                    work.phase            = pps_pkg::PH_READY;
                    o_emit.emit           = 1'b1;
                    o_emit.evt.from_state = pps_pkg::PH_WAITING;
                    o_emit.evt.new_state  = pps_pkg::PH_READY;
                    if (i_ack.emit_ok) begin
                        slot_we    = 1'b1;
                        slot_waddr = r_ws;
                        slot_wdata = work;
                        n_k        = r_k + CW'(1);
                        n_state    = pps_pkg::S_WF_RD;
                    end
                end else begin
                    slot_we    = 1'b1;
                    slot_waddr = r_ws;
                    slot_wdata = work;
                    fifo_we    = 1'b1;
                    fifo_waddr = r_kept[SW-1:0];
                    fifo_wdata = r_ws;
                    n_kept     = r_kept + CW'(1);
                    n_k        = r_k + CW'(1);
                    n_state    = pps_pkg::S_WF_RD;
                end
            end
            pps_pkg::S_WAPPEND: begin
                n_wcnt = r_kept;
                if (r_act == pps_pkg::RA_WAIT && r_kept < CW'(MAX_PROCESSES)) begin
                    fifo_we    = 1'b1;
                    fifo_waddr = r_kept[SW-1:0];
                    fifo_wdata = r_run;
                    n_wcnt     = r_kept + CW'(1);
                end
                n_state = pps_pkg::S_RUN_EMIT;
            end
            pps_pkg::S_RUN_EMIT: begin
                n_scan    = '0;
                n_sv      = 1'b0;
                n_best_ok = 1'b0;
                if (r_act != pps_pkg::RA_NONE) begin
                    o_emit.emit           = 1'b1;
                    o_emit.evt.proc_id    = r_run_pid;
                    o_emit.evt.from_state = pps_pkg::PH_RUNNING;
                    o_emit.evt.new_state  = (r_act == pps_pkg::RA_TERM) ? pps_pkg::PH_TERMINATED
                                                                        : pps_pkg::PH_WAITING;
                end
                if (r_act == pps_pkg::RA_NONE || i_ack.emit_ok) begin
                    n_state = r_busy ? pps_pkg::S_TICK_END : pps_pkg::S_SCAN;
                end
            end
            pps_pkg::S_SCAN: begin
                if (r_sv && ent.phase == pps_pkg::PH_READY &&
                    (!r_best_ok || ent.pid < r_best_ent.pid)) begin
                    n_best     = r_sidx;
                    n_best_ok  = 1'b1;
                    n_best_ent = ent;
                end
                if (r_scan < r_fill) begin
                    slot_re    = 1'b1;
                    slot_raddr = r_scan[SW-1:0];
                    n_sidx     = r_scan[SW-1:0];
                    n_scan     = r_scan + CW'(1);
                    n_sv       = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = pps_pkg::S_DISP;
                    end
                end
            end
            pps_pkg::S_DISP: begin
                if (r_best_ok) begin
                    o_emit.emit           = 1'b1;
                    o_emit.evt.proc_id    = r_best_ent.pid;
                    o_emit.evt.from_state = pps_pkg::PH_READY;
                    o_emit.evt.new_state  = pps_pkg::PH_RUNNING;
                    if (i_ack.emit_ok) begin
                        slot_we          = 1'b1;
                        slot_waddr       = r_best;
                        slot_wdata       = r_best_ent;
                        slot_wdata.phase = pps_pkg::PH_RUNNING;
                        n_run            = r_best;
                        n_busy           = 1'b1;
                        n_state          = pps_pkg::S_TICK_END;
                    end
                end else begin
                    n_state = pps_pkg::S_TICK_END;
                end
            end
            pps_pkg::S_TICK_END: begin
                n_tick  = r_tick + 32'd1;
                n_state = pps_pkg::S_FINISH;
            end
            pps_pkg::S_FINISH: begin
                o_emit.fin = 1'b1;
                if (i_ack.fin_ok) begin
                    n_state = pps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pps_pkg::S_IDLE;
            r_fill    <= '0;
            r_live    <= '0;
            r_wcnt    <= '0;
            r_k       <= '0;
            r_kept    <= '0;
            r_scan    <= '0;
            r_sv      <= 1'b0;
            r_run     <= '0;
            r_busy    <= 1'b0;
            r_tick    <= '0;
            r_act     <= pps_pkg::RA_NONE;
            r_best_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_live    <= n_live;
            r_wcnt    <= n_wcnt;
            r_k       <= n_k;
            r_kept    <= n_kept;
            r_scan    <= n_scan;
            r_sv      <= n_sv;
            r_run     <= n_run;
            r_busy    <= n_busy;
            r_tick    <= n_tick;
            r_act     <= n_act;
            r_best_ok <= n_best_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_sidx     <= n_sidx;
        r_run_pid  <= n_run_pid;
        r_ws       <= n_ws;
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
    end

    `PPS_ASSERT(a_live_le_fill, r_live <= r_fill)
    `PPS_ASSERT(a_wait_le_fill, r_wcnt <= r_fill)
    `PPS_ASSERT(a_run_occupied, !r_busy || (CW'(r_run) < r_fill))
    `PPS_ASSERT_NEXT(a_tick_adv, r_state == pps_pkg::S_TICK_END, r_tick == $past(r_tick) + 32'd1)
    `PPS_ASSERT_NEXT(a_admit_fill, admit_wr, r_fill == $past(r_fill) + CW'(1))
endmodule

FILE: rtl/priority_process_scheduler_tick.sv
// Non-preemptive priority process scheduler, stepped one tick per tick request.
// Channels: i_req (pps_req_if sink) takes admit and tick requests; o_res
// (pps_res_if source) delivers one result per process state change or
// rejected admit, with last set on the final one caused by an input
// request. valid/ready on both. A tick charges the running process, then
// walks the wait list (fifo read, slot read, write back for each waiting
// process); when no process holds the CPU, a dispatch scan sweeps the
// occupied slots one per cycle through the slot RAM read port. A new
// request is accepted only after the previous one has finished.
// Reset (synchronous, i_rst_n low) empties the table via a fill count, clears
// the wait list, the tick count and the CPU; no clearing pass is needed.
// When the receiver stalls, the block holds one result in its output
// register and one more in a hold stage; further results stall the
// sequencer until o_res.ready returns. Nothing is dropped.
// Depends on pps_pkg, pps_if, pps_ram, pps_emit and pps_ctrl.
module priority_process_scheduler_tick #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pps_req_if.sink     i_req,
    pps_res_if.source   o_res
);
    pps_pkg::t_emit_req emit_req;
    pps_pkg::t_emit_ack emit_ack;
    logic               all_done;

    // sequencer: walks the wait list, charges the CPU, dispatches
    pps_ctrl #(.MAX_PROCESSES(MAX_PROCESSES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_emit     (emit_req),
        .i_ack      (emit_ack),
        .o_all_done (all_done)
    );

    // output stage: holds one result back to mark the last one
    pps_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (emit_req),
        .i_all_done (all_done),
        .o_ack      (emit_ack),
        .o_res      (o_res)
    );
endmodule
